// ----- design/assert_macros.svh -----
// Assertion macros used by the design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define HV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define HV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/hvng_pkg.sv -----
// Types, constants and step functions of the heightmap vertex normal generator.
package hvng_pkg;

	localparam int DIM_W  = 11;
	localparam int H_W    = 16;
	localparam int POS_W  = 12;
	localparam int N_W    = 16;
	localparam int NY_W   = 15;
	localparam int TEX_W  = 16;
	localparam int QB_W   = 20;
	localparam int CFGI_W = 2;
	localparam int CFGD_W = 16;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_DEPTH = 1024;

	// normal solver widths
	localparam int S_W  = 34;
	localparam int R_W  = 62;
	localparam int P_W  = 64;
	localparam int Q_W  = 50;
	localparam int TR_W = 68;
	localparam int IT_W = 4;

	localparam logic [NY_W-1:0] Q14_ONE = NY_W'(16384);
	// 2.0 in Q8.8, squared
	localparam logic [S_W-1:0] NORM_Y_SQ = S_W'(262144);
	localparam logic [R_W-1:0] NORM_Y_R  = R_W'(262144) << 30;

	localparam logic [CFGI_W-1:0] CFG_GRID_WIDTH    = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_GRID_DEPTH    = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_TEXTURE_SCALE = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_C,
		ST_RD_R,
		ST_PREP,
		ST_SQ,
		ST_ITER,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [P_W-1:0]        p;
		logic signed [Q_W-1:0] q;
		logic [NY_W-1:0]       n;
	} nrm_lane_t;

	typedef struct packed {
		logic [12:0]  r;
		logic [15:0]  num;
		logic [15:0]  quo;
	} div_lane_t;

	// Start a lane with n = 0, i.e. t = -1
	function automatic nrm_lane_t nrm_init(logic [S_W-1:0] s);
		nrm_lane_t l;
		l.p = P_W'(s);
		l.q = Q_W'(0) - $signed(Q_W'(s));
		l.n = '0;
		return l;
	endfunction

	// Try setting bit k of n: keep it when (2n-1)^2 * s stays within r
	function automatic nrm_lane_t nrm_step(nrm_lane_t cur, logic [S_W-1:0] s,
		logic [R_W-1:0] r, logic [IT_W-1:0] k);
		logic signed [TR_W-1:0] qx;
		logic signed [TR_W-1:0] sx;
		logic signed [TR_W-1:0] trial;
		logic [5:0]             sh1;
		logic [5:0]             sh2;
		logic [NY_W-1:0]        tn;
		nrm_lane_t              nx;
		qx    = TR_W'(cur.q);
		sx    = $signed(TR_W'(s));
		sh1   = 6'(k) + 6'd2;
		sh2   = 6'(k) + 6'(k) + 6'd2;
		trial = $signed(TR_W'(cur.p)) + (qx <<< sh1) + (sx <<< sh2);
		tn    = cur.n | (NY_W'(1) << k);
		nx    = cur;
		if (tn <= Q14_ONE && trial <= $signed(TR_W'(r))) begin
			nx.n = tn;
			nx.p = P_W'(trial);
			nx.q = cur.q + Q_W'(sx <<< (sh1 - 6'd1));
		end
		return nx;
	endfunction

	// One restoring division step, quotient bit from the divisor compare
	function automatic div_lane_t div_step(div_lane_t cur, logic [12:0] dv);
		logic [12:0] r2;
		div_lane_t   nx;
		r2     = {cur.r[11:0], cur.num[15]};
		nx.num = {cur.num[14:0], 1'b0};
		if (r2 >= dv) begin
			nx.r   = r2 - dv;
			nx.quo = {cur.quo[14:0], 1'b1};
		end else begin
			nx.r   = r2;
			nx.quo = {cur.quo[14:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

// ----- design/heightmap_vertex_normal_generator.sv -----
// Heightmap vertex normal generator: line buffers, normal solver and texture divider.
// An item with no result is accepted without leaving the idle state. An item that yields a vertex
// goes from acceptance to the output register through two line buffer reads, one operand step, one
// squaring step and 16 steps of the shared bit-serial loop (texture divider; the normal solver uses 15).
// The next item is taken as soon as the vertex sits in the output register.
// Reset clears state, configuration and counters to defaults; line buffers and datapath registers hold no reset value.
`include "assert_macros.svh"

module heightmap_vertex_normal_generator #(
	parameter int MAX_WIDTH = hvng_pkg::DEF_MAX_WIDTH,
	parameter int MAX_DEPTH = hvng_pkg::DEF_MAX_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hvng_pkg::CFGI_W-1:0]       cfg_index,
	input  logic [hvng_pkg::CFGD_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic signed [hvng_pkg::H_W-1:0]   height,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [hvng_pkg::POS_W-1:0] pos_x,
	output logic signed [hvng_pkg::H_W-1:0]   pos_y,
	output logic signed [hvng_pkg::POS_W-1:0] pos_z,
	output logic signed [hvng_pkg::N_W-1:0]   norm_x,
	output logic [hvng_pkg::NY_W-1:0]         norm_y,
	output logic signed [hvng_pkg::N_W-1:0]   norm_z,
	output logic [hvng_pkg::TEX_W-1:0]        tex_u,
	output logic [hvng_pkg::TEX_W-1:0]        tex_v,
	output logic [hvng_pkg::QB_W-1:0]         quad_base,
	output logic                              quad_valid,
	output logic                              last
);

	localparam int DW = hvng_pkg::DIM_W;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = ((AW > DW) ? AW : DW) + 1;

	hvng_pkg::state_t state_q, state_d;

	logic [DW-1:0]               w_cfg_q, d_cfg_q;
	logic [hvng_pkg::TEX_W-1:0]  scale_q;
	logic [DW-1:0]               w_eff, d_eff;
	logic [CW-1:0]               col_q;
	logic [DW-1:0]               rc_q;
	logic [hvng_pkg::QB_W-1:0]   vc_q;

	// item registers
	logic [CW-1:0]               x_q;
	logic [DW-1:0]               z_q;
	logic signed [hvng_pkg::H_W-1:0] h_q, hc_q, hl_q;
	logic                        flush_q;
	logic [hvng_pkg::QB_W-1:0]   vb_q;

	// line buffers
	logic signed [hvng_pkg::H_W-1:0] row_mid [MAX_WIDTH];
	logic signed [hvng_pkg::H_W-1:0] row_abv [MAX_WIDTH];
	logic signed [hvng_pkg::H_W-1:0] mid_rd_q, abv_rd_q;
	logic                        mid_re, abv_re, mid_we, abv_we;
	logic [AW-1:0]               mid_raddr, mid_waddr;
	logic signed [hvng_pkg::H_W-1:0] mid_wdata;

	// arithmetic
	logic [15:0]                 ax_q, az_q;
	logic                        dxn_q, dzn_q;
	logic [26:0]                 pu_q, pv_q;
	logic [hvng_pkg::S_W-1:0]    s_d, s_q;
	logic [31:0]                 ax2_d, az2_d;
	logic [hvng_pkg::R_W-1:0]    rx_q, rz_q;
	hvng_pkg::nrm_lane_t         lx_q, ly_q, lz_q;
	hvng_pkg::div_lane_t         du_l_q, dv_l_q;
	logic [hvng_pkg::IT_W-1:0]   it_q;
	logic [12:0]                 du_d, dv_d;
	logic [27:0]                 nu_d, nv_d;

	// acceptance decode
	logic                        in_acc, cfg_acc;
	logic                        restart_now, wrap, live_s, live_f, emit;
	logic [CW-1:0]               x_eff, x_next;
	logic [DW-1:0]               rc_eff;
	logic [hvng_pkg::QB_W-1:0]   vc_eff;
	logic signed [hvng_pkg::H_W-1:0] hr_d, hl_d, hu_d, hd_d;
	logic signed [hvng_pkg::H_W:0]   dx_d, dz_d;
	logic                        out_load;

	// Clamp the grid size registers
	always_comb begin
		if (w_cfg_q == '0) w_eff = DW'(1);
		else if (32'(w_cfg_q) > MAX_WIDTH) w_eff = DW'(MAX_WIDTH);
		else w_eff = w_cfg_q;
		if (d_cfg_q == '0) d_eff = DW'(1);
		else if (32'(d_cfg_q) > MAX_DEPTH) d_eff = DW'(MAX_DEPTH);
		else d_eff = d_cfg_q;
	end

	// Decode an incoming item against the raster position
	always_comb begin
		in_acc      = in_valid && in_ready;
		cfg_acc     = cfg_valid && cfg_ready;
		restart_now = col_q >= CW'(w_eff);
		x_eff       = restart_now ? '0 : col_q;
		rc_eff      = restart_now ? '0 : rc_q;
		vc_eff      = restart_now ? '0 : vc_q;
		x_next      = x_eff + CW'(1);
		wrap        = x_next >= CW'(w_eff);
		live_s      = rc_eff < d_eff;
		live_f      = rc_eff >= d_eff;
		emit        = (opcode == hvng_pkg::OP_SAMPLE) ? (live_s && rc_eff != '0) : live_f;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hvng_pkg::ST_IDLE: begin
				if (in_acc && emit) state_d = hvng_pkg::ST_RD_C;
			end
			hvng_pkg::ST_RD_C: state_d = hvng_pkg::ST_RD_R;
			hvng_pkg::ST_RD_R: state_d = hvng_pkg::ST_PREP;
			hvng_pkg::ST_PREP: state_d = hvng_pkg::ST_SQ;
			hvng_pkg::ST_SQ:   state_d = hvng_pkg::ST_ITER;
			hvng_pkg::ST_ITER: begin
				if (it_q == '0) state_d = hvng_pkg::ST_DONE;
			end
			hvng_pkg::ST_DONE: begin
				if (!out_valid || out_ready) state_d = hvng_pkg::ST_IDLE;
			end
			default: state_d = hvng_pkg::ST_IDLE;
		endcase
	end

	// State outputs: handshakes and buffer port controls
	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		mid_re    = 1'b0;
		abv_re    = 1'b0;
		abv_we    = 1'b0;
		out_load  = 1'b0;
		mid_raddr = x_q[AW-1:0];
		case (state_q)
			hvng_pkg::ST_IDLE: begin
				// a pending register write goes first, hold the item meanwhile
				in_ready  = !cfg_valid;
				cfg_ready = 1'b1;
			end
			hvng_pkg::ST_RD_C: begin
				mid_re = 1'b1;
				abv_re = 1'b1;
			end
			hvng_pkg::ST_RD_R: begin
				mid_re    = 1'b1;
				mid_raddr = x_q[AW-1:0] + AW'(1);
			end
			hvng_pkg::ST_PREP: abv_we = 1'b1;
			hvng_pkg::ST_DONE: out_load = !out_valid || out_ready;
			default: ;
		endcase
	end

	// Middle row write: plain store on a first-row sample, late store after the read
	always_comb begin
		if (state_q == hvng_pkg::ST_PREP) begin
			mid_we    = !flush_q;
			mid_waddr = x_q[AW-1:0];
			mid_wdata = h_q;
		end else begin
			mid_we    = in_acc && opcode == hvng_pkg::OP_SAMPLE && live_s && !emit;
			mid_waddr = x_eff[AW-1:0];
			mid_wdata = height;
		end
	end

	// Line buffer memories
	always_ff @(posedge clk) begin
		if (mid_we) row_mid[mid_waddr] <= mid_wdata;
		if (mid_re) mid_rd_q <= row_mid[mid_raddr];
	end

	always_ff @(posedge clk) begin
		if (abv_we) row_abv[x_q[AW-1:0]] <= hc_q;
		if (abv_re) abv_rd_q <= row_abv[x_q[AW-1:0]];
	end

	// Neighbour selection with edge clamping
	always_comb begin
		hr_d  = (x_q + CW'(1) < CW'(w_eff)) ? mid_rd_q : hc_q;
		hl_d  = (x_q != '0) ? hl_q : hc_q;
		hu_d  = (z_q != '0) ? abv_rd_q : hc_q;
		hd_d  = flush_q ? hc_q : h_q;
		dx_d  = {hl_d[hvng_pkg::H_W-1], hl_d} - {hr_d[hvng_pkg::H_W-1], hr_d};
		dz_d  = {hu_d[hvng_pkg::H_W-1], hu_d} - {hd_d[hvng_pkg::H_W-1], hd_d};
		ax2_d = 32'(ax_q) * 32'(ax_q);
		az2_d = 32'(az_q) * 32'(az_q);
		s_d   = hvng_pkg::S_W'(ax2_d) + hvng_pkg::S_W'(az2_d) + hvng_pkg::NORM_Y_SQ;
		du_d  = {1'b0, w_eff, 1'b0};
		dv_d  = {1'b0, d_eff, 1'b0};
		nu_d  = {pu_q, 1'b0} + 28'(w_eff);
		nv_d  = {pv_q, 1'b0} + 28'(d_eff);
	end

	// Control registers: state, configuration, raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hvng_pkg::ST_IDLE;
			w_cfg_q <= DW'(1024);
			d_cfg_q <= DW'(1024);
			scale_q <= hvng_pkg::TEX_W'(256);
			col_q   <= '0;
			rc_q    <= '0;
			vc_q    <= '0;
		end else begin
			state_q <= state_d;
			// advance the raster position on each accepted item that is live for its opcode
			if (in_acc) begin
				col_q <= x_eff;
				rc_q  <= rc_eff;
				vc_q  <= vc_eff;
				if (opcode == hvng_pkg::OP_SAMPLE) begin
					if (live_s) begin
						col_q <= wrap ? '0 : x_next;
						rc_q  <= rc_eff + DW'(wrap);
						vc_q  <= vc_eff + hvng_pkg::QB_W'(emit);
					end
				end else if (live_f) begin
					if (wrap) begin
						col_q <= '0;
						rc_q  <= '0;
						vc_q  <= '0;
					end else begin
						col_q <= x_next;
						vc_q  <= vc_eff + hvng_pkg::QB_W'(1);
					end
				end
			end
			// register writes; a grid size write restarts the frame
			if (cfg_acc) begin
				case (cfg_index)
					hvng_pkg::CFG_GRID_WIDTH: begin
						w_cfg_q <= cfg_data[DW-1:0];
						col_q   <= '0;
						rc_q    <= '0;
						vc_q    <= '0;
					end
					hvng_pkg::CFG_GRID_DEPTH: begin
						d_cfg_q <= cfg_data[DW-1:0];
						col_q   <= '0;
						rc_q    <= '0;
						vc_q    <= '0;
					end
					hvng_pkg::CFG_TEXTURE_SCALE: scale_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath registers of the vertex in flight
	always_ff @(posedge clk) begin
		case (state_q)
			hvng_pkg::ST_IDLE: begin
				x_q     <= x_eff;
				z_q     <= (opcode == hvng_pkg::OP_SAMPLE) ? rc_eff - DW'(1) : d_eff - DW'(1);
				h_q     <= height;
				flush_q <= opcode == hvng_pkg::OP_FLUSH;
				vb_q    <= vc_eff;
			end
			hvng_pkg::ST_RD_R: hc_q <= mid_rd_q;
			hvng_pkg::ST_PREP: begin
				hl_q  <= hc_q;
				dxn_q <= dx_d[hvng_pkg::H_W];
				dzn_q <= dz_d[hvng_pkg::H_W];
				ax_q  <= dx_d[hvng_pkg::H_W] ? 16'(-dx_d) : 16'(dx_d);
				az_q  <= dz_d[hvng_pkg::H_W] ? 16'(-dz_d) : 16'(dz_d);
				pu_q  <= 27'(scale_q) * 27'(x_q);
				pv_q  <= 27'(scale_q) * 27'(z_q);
			end
			hvng_pkg::ST_SQ: begin
				s_q    <= s_d;
				rx_q   <= hvng_pkg::R_W'(ax2_d) << 30;
				rz_q   <= hvng_pkg::R_W'(az2_d) << 30;
				lx_q   <= hvng_pkg::nrm_init(s_d);
				ly_q   <= hvng_pkg::nrm_init(s_d);
				lz_q   <= hvng_pkg::nrm_init(s_d);
				du_l_q <= '{r: 13'(nu_d[27:16]), num: nu_d[15:0], quo: '0};
				dv_l_q <= '{r: 13'(nv_d[27:16]), num: nv_d[15:0], quo: '0};
				it_q   <= hvng_pkg::IT_W'(15);
			end
			hvng_pkg::ST_ITER: begin
				// one quotient bit per cycle; the normal lanes set bit it_q-1 and rest on the last step
				du_l_q <= hvng_pkg::div_step(du_l_q, du_d);
				dv_l_q <= hvng_pkg::div_step(dv_l_q, dv_d);
				if (it_q != '0) begin
					lx_q <= hvng_pkg::nrm_step(lx_q, s_q, rx_q, it_q - hvng_pkg::IT_W'(1));
					ly_q <= hvng_pkg::nrm_step(ly_q, s_q, hvng_pkg::NORM_Y_R,
						it_q - hvng_pkg::IT_W'(1));
					lz_q <= hvng_pkg::nrm_step(lz_q, s_q, rz_q, it_q - hvng_pkg::IT_W'(1));
				end
				it_q <= it_q - hvng_pkg::IT_W'(1);
			end
			default: ;
		endcase
	end

	// Output register: load a finished vertex, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x      <= hvng_pkg::POS_W'({x_q, 1'b0}) - hvng_pkg::POS_W'(w_eff);
			pos_y      <= hc_q;
			pos_z      <= hvng_pkg::POS_W'({z_q, 1'b0}) - hvng_pkg::POS_W'(d_eff);
			norm_x     <= dxn_q ? hvng_pkg::N_W'(0) - hvng_pkg::N_W'(lx_q.n)
				: hvng_pkg::N_W'(lx_q.n);
			norm_y     <= ly_q.n;
			norm_z     <= dzn_q ? hvng_pkg::N_W'(0) - hvng_pkg::N_W'(lz_q.n)
				: hvng_pkg::N_W'(lz_q.n);
			tex_u      <= du_l_q.quo;
			tex_v      <= dv_l_q.quo;
			quad_base  <= vb_q;
			quad_valid <= (x_q + CW'(1) < CW'(w_eff)) && (z_q + DW'(1) < d_eff);
			last       <= (x_q + CW'(1) == CW'(w_eff)) && (z_q + DW'(1) == d_eff);
		end
	end

	`HV_ASSERT_IMP(a_col_in_range, clk, arst_n, 1'b1, col_q < CW'(w_eff))
	`HV_ASSERT_IMP(a_row_in_range, clk, arst_n, 1'b1, rc_q <= d_eff)
	`HV_ASSERT_IMP(a_div_rem, clk, arst_n, state_q == hvng_pkg::ST_ITER, du_l_q.r < du_d && dv_l_q.r < dv_d)
	`HV_ASSERT_NXT(a_iter_end, clk, arst_n, state_q == hvng_pkg::ST_ITER && it_q == '0, state_q == hvng_pkg::ST_DONE)
	`HV_ASSERT_IMP(a_norm_cap, clk, arst_n, state_q == hvng_pkg::ST_DONE, ly_q.n <= hvng_pkg::Q14_ONE && lx_q.n <= hvng_pkg::Q14_ONE)

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the heightmap vertex normal generator.
module tb;
	import hvng_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [H_W-1:0]   py;
		logic signed [POS_W-1:0] pz;
		logic signed [N_W-1:0]   nx;
		logic [NY_W-1:0]         ny;
		logic signed [N_W-1:0]   nz;
		logic [TEX_W-1:0]        tu;
		logic [TEX_W-1:0]        tv;
		logic [QB_W-1:0]         qb;
		logic                    qv;
		logic                    lst;
	} vertex_t;

	typedef struct {
		bit               is_cfg;
		logic [CFGI_W-1:0] idx;
		logic [15:0]      val;
		logic             op;
		bit               typed;
		vertex_t          exp;
	} stim_row_t;

	localparam logic [CFGI_W-1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYC = 30;
	localparam int HOLD_CYC   = 400;
	localparam int CUT_MAX    = 48;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [CFGD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic opcode = OP_SAMPLE;
	logic signed [H_W-1:0] height = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [POS_W-1:0] pos_x, pos_z;
	logic signed [H_W-1:0] pos_y;
	logic signed [N_W-1:0] norm_x, norm_z;
	logic [NY_W-1:0] norm_y;
	logic [TEX_W-1:0] tex_u, tex_v;
	logic [QB_W-1:0] quad_base;
	logic quad_valid, last;

	heightmap_vertex_normal_generator u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: configuration, line buffers and counters
	int unsigned gw_raw = 1024, gd_raw = 1024, tscale = 256;
	logic signed [H_W-1:0] buf_above [1024];
	logic signed [H_W-1:0] buf_mid [1024];
	int unsigned col_pos, row_pos, vtx_index;
	logic signed [H_W-1:0] left_h;

	vertex_t vertex_q[$];
	bit      cur_typed = 1'b0;
	vertex_t cur_exp;
	int      errors = 0;
	bit      quiet = 1'b0;
	bit      hold_go = 1'b0;
	int      sent = 0;

	function automatic int unsigned clamp_dim(int unsigned v);
		if (v < 1) return 1;
		if (v > 1024) return 1024;
		return v;
	endfunction

	// Largest n in [0,16384] with (2n-1)^2 * s <= (2*a*16384)^2
	function automatic int unsigned unit_q14(longint unsigned a, longint unsigned s);
		longint unsigned num2, lo, hi, mid, t;
		num2 = (a * 32768) * (a * 32768);
		lo = 0;
		hi = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (t * t * s <= num2) lo = mid;
			else hi = mid - 1;
		end
		return int'(lo);
	endfunction

	function automatic logic [15:0] tex_coord(int unsigned i, int unsigned n);
		longint unsigned v;
		v = (longint'(tscale) * i * 2 + n) / (2 * n);
		return v[15:0];
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		vtx_index = 0;
		left_h = '0;
	endfunction

	// Build the vertex at (x, z) of the buffered middle row
	function automatic vertex_t make_vertex(int unsigned x, int unsigned z,
		logic signed [H_W-1:0] hd_in, bit clamp_down);
		int unsigned w, d, nx_mag, nz_mag;
		int hc, hr, hl, hu, hd, dx, dz;
		longint unsigned ax, az, s;
		vertex_t v;
		w = clamp_dim(gw_raw);
		d = clamp_dim(gd_raw);
		hc = buf_mid[x];
		hr = (x + 1 < w) ? int'(buf_mid[x+1]) : hc;
		hl = (x > 0) ? int'(left_h) : hc;
		hu = (z > 0) ? int'(buf_above[x]) : hc;
		hd = clamp_down ? hc : int'(hd_in);
		dx = hl - hr;
		dz = hu - hd;
		ax = (dx < 0) ? -dx : dx;
		az = (dz < 0) ? -dz : dz;
		s = ax * ax + 262144 + az * az;
		nx_mag = unit_q14(ax, s);
		nz_mag = unit_q14(az, s);
		v.px = POS_W'(2 * x - w);
		v.py = H_W'(hc);
		v.pz = POS_W'(2 * z - d);
		v.nx = (dx < 0) ? N_W'(-nx_mag) : N_W'(nx_mag);
		v.ny = NY_W'(unit_q14(512, s));
		v.nz = (dz < 0) ? N_W'(-nz_mag) : N_W'(nz_mag);
		v.tu = tex_coord(x, w);
		v.tv = tex_coord(z, d);
		v.qb = QB_W'(vtx_index);
		v.qv = (x + 1 < w) && (z + 1 < d);
		v.lst = (x + 1 == w) && (z + 1 == d);
		vtx_index = (vtx_index + 1) & 32'hFFFFF;
		left_h = H_W'(hc);
		buf_above[x] = H_W'(hc);
		return v;
	endfunction

	// Advance the shadow by one item; returns 1 when a vertex comes out
	function automatic bit advance_grid(logic op, logic signed [H_W-1:0] h, output vertex_t v);
		int unsigned w, d, x;
		bit produced;
		w = clamp_dim(gw_raw);
		d = clamp_dim(gd_raw);
		x = col_pos;
		produced = 1'b0;
		if (x >= w) begin
			restart_frame();
			x = 0;
		end
		if (op == OP_SAMPLE) begin
			if (row_pos >= d) return 1'b0;
			if (row_pos > 0) begin
				v = make_vertex(x, row_pos - 1, h, 1'b0);
				produced = 1'b1;
			end
			buf_mid[x] = h;
			x++;
			if (x >= w) begin
				x = 0;
				row_pos++;
			end
			col_pos = x;
		end else begin
			if (row_pos < d) return 1'b0;
			v = make_vertex(x, d - 1, '0, 1'b1);
			produced = 1'b1;
			x++;
			if (x >= w) restart_frame();
			else col_pos = x;
		end
		return produced;
	endfunction

	// Track accepted items and check results
	always @(posedge clk) begin
		vertex_t pv, got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GRID_WIDTH: begin
						gw_raw = cfg_data & 16'h7FF;
						restart_frame();
					end
					CFG_GRID_DEPTH: begin
						gd_raw = cfg_data & 16'h7FF;
						restart_frame();
					end
					CFG_TEXTURE_SCALE: tscale = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
					quad_base, quad_valid, last};
				if (vertex_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected vertex %p", got);
				end else begin
					pv = vertex_q.pop_front();
					if (got !== pv) begin
						errors++;
						if (errors <= 10) $display("vertex mismatch: exp %p got %p", pv, got);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (advance_grid(opcode, height, pv))
					vertex_q.push_back(cur_typed ? cur_exp : pv);
			end
		end
	end

	// Receiver: random stalls, one long hold-off on request
	always @(negedge clk) begin
		int hold_cnt;
		if (hold_go) begin
			hold_go = 1'b0;
			hold_cnt = HOLD_CYC;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready = 1'b0;
		end else begin
			out_ready = quiet || ($urandom_range(99) >= 8);
		end
	end

	task automatic send_item(logic op, logic signed [H_W-1:0] h, bit typed = 0,
		vertex_t exp = '0);
		while (!quiet && $urandom_range(99) < 8) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		height = h;
		cur_typed = typed;
		cur_exp = exp;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
		sent++;
	endtask

	// Let the block drain before touching a register
	task automatic settle();
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFGI_W-1:0] idx, logic [15:0] val);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [H_W-1:0] rand_height();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return H_W'($urandom);
		endcase
	endfunction

	// Random frame; shape 0 is noise, 1 is a frame cut short, else well formed
	task automatic run_frame(int unsigned w, int unsigned d, int shape);
		int unsigned wc, dc, n;
		wc = clamp_dim(w & 32'h7FF);
		dc = clamp_dim(d & 32'h7FF);
		if (shape == 0) begin
			repeat (8) send_item(logic'($urandom_range(1)), rand_height());
		end else begin
			n = (shape == 1) ? $urandom_range(wc * dc) : wc * dc;
			// keep cut frames on large grids short
			if (shape == 1 && n > CUT_MAX) n = CUT_MAX;
			for (int unsigned i = 0; i < n; i++) begin
				if (i == 0 && $urandom_range(3) == 0) send_item(OP_FLUSH, rand_height());
				send_item(OP_SAMPLE, rand_height());
			end
			if (shape != 1) begin
				if ($urandom_range(3) == 0) send_item(OP_SAMPLE, rand_height());
				for (int unsigned i = 0; i < wc; i++) send_item(OP_FLUSH, rand_height());
			end
		end
	endtask

	function automatic vertex_t lone_vertex(logic signed [H_W-1:0] h);
		return '{-12'sd1, h, -12'sd1, 16'sd0, 15'd16384, 16'sd0, 16'd0, 16'd0,
			20'd0, 1'b0, 1'b1};
	endfunction

	initial begin
		stim_row_t rows[$];
		int unsigned w, d, f;
		rows = '{
			'{1, CFG_GRID_WIDTH, 16'd1, 0, 0, '0},
			'{1, CFG_GRID_DEPTH, 16'd1, 0, 0, '0},
			'{1, CFG_TEXTURE_SCALE, 16'd256, 0, 0, '0},
			'{0, '0, 16'h0000, OP_FLUSH, 0, '0},
			'{0, '0, 16'h1234, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h7FFF, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h0000, OP_FLUSH, 1, lone_vertex(16'sh1234)},
			'{0, '0, 16'h0000, OP_FLUSH, 0, '0},
			'{0, '0, 16'h8000, OP_SAMPLE, 0, '0},
			'{0, '0, 16'hFFFF, OP_FLUSH, 1, lone_vertex(16'sh8000)},
			'{1, CFG_GRID_WIDTH, 16'd3, 0, 0, '0},
			'{1, CFG_GRID_DEPTH, 16'd2, 0, 0, '0},
			'{1, CFG_TEXTURE_SCALE, 16'hFFFF, 0, 0, '0},
			'{1, CFG_UNUSED, 16'h5A5A, 0, 0, '0},
			'{0, '0, 16'h7FFF, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h8000, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h0001, OP_SAMPLE, 0, '0},
			'{0, '0, 16'hFFFF, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h0000, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h7FFF, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h8000, OP_SAMPLE, 0, '0},
			'{0, '0, 16'h0000, OP_FLUSH, 0, '0},
			'{0, '0, 16'h0000, OP_FLUSH, 0, '0},
			'{0, '0, 16'h0000, OP_FLUSH, 0, '0},
			'{0, '0, 16'h0000, OP_FLUSH, 0, '0}
		};
		restart_frame();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
			else send_item(rows[i].op, rows[i].val, rows[i].typed, rows[i].exp);
		end

		// Random frames, with the extreme sizes on fixed frames
		f = 0;
		while (sent < 680) begin
			case (f)
				3: begin w = 16'hFFFF; d = 2; end
				6: begin w = 1; d = 16'hFFFF; end
				9: begin w = 0; d = 0; end
				12: begin w = 1024; d = 1; end
				default: begin w = $urandom_range(1, 6); d = $urandom_range(1, 5); end
			endcase
			if (f == 5) begin
				w = 5;
				d = 5;
			end
			quiet = (f == 4);
			write_reg(CFG_GRID_WIDTH, 16'(w));
			write_reg(CFG_GRID_DEPTH, 16'(d));
			case ($urandom_range(4))
				0: write_reg(CFG_TEXTURE_SCALE, 16'h0000);
				1: write_reg(CFG_TEXTURE_SCALE, 16'hFFFF);
				2: write_reg(CFG_UNUSED, 16'($urandom));
				default: write_reg(CFG_TEXTURE_SCALE, 16'($urandom));
			endcase
			if (f == 5) hold_go = 1'b1;
			if (f == 3 || f == 6 || f == 12) run_frame(w, d, 1);
			else if (f < 13) run_frame(w, d, 2);
			else run_frame(w, d, $urandom_range(9));
			f++;
		end
		quiet = 1'b0;

		// Drain and report
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (vertex_q.size() != 0) errors++;
		if (errors == 0) begin
			$display("heightmap_vertex_normal_generator verification clean");
		end else begin
			$display("heightmap_vertex_normal_generator verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("heightmap_vertex_normal_generator verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/hvng_pkg.sv
design/heightmap_vertex_normal_generator.sv
dv/tb.sv
